FILE: hdl/mfce_pkg.sv
// ----------------------------------------------------------------------------
// Markov frequency cache eviction: shared definitions
// Sizes, field widths, operation codes, register indexes and helpers.
// ----------------------------------------------------------------------------
package mfce_pkg;

  localparam int ALPHABET   = 32;
  localparam int SLOTS      = 16;
  localparam int COUNT_BITS = 16;

  localparam int KEY_W      = $clog2(ALPHABET);
  localparam int SLOT_W     = $clog2(SLOTS);
  localparam int TRANS_AW   = 2 * KEY_W;
  localparam int USED_W     = $clog2(SLOTS + 1);
  localparam int CNT_W      = $clog2(SLOTS + 2);
  localparam int VALUE_W    = 32;
  localparam int MODE_W     = 2;
  localparam int CAP_W      = 5;
  localparam int GAMMA_W    = 9;
  localparam int GFC_W      = GAMMA_W + COUNT_BITS;
  localparam int P1_W       = GFC_W + COUNT_BITS;
  localparam int P2_W       = GAMMA_W + COUNT_BITS;
  localparam int SCORE_W    = P1_W + 1;
  localparam int S_DATA_W   = ((KEY_W + VALUE_W + 7) / 8) * 8;
  localparam int M_DATA_W   = ((VALUE_W + KEY_W + 7) / 8) * 8;
  localparam int M_USER_W   = 2;

  localparam logic [MODE_W-1:0]  MODE_GET    = 2'd0;
  localparam logic [MODE_W-1:0]  MODE_SET    = 2'd1;
  localparam logic [MODE_W-1:0]  MODE_REMOVE = 2'd2;

  localparam logic REG_CAPACITY = 1'b0;
  localparam logic REG_GAMMA    = 1'b1;

  localparam logic [CAP_W-1:0]   CAP_RESET   = CAP_W'(16);
  localparam logic [GAMMA_W-1:0] GAMMA_RESET = GAMMA_W'(128);
  localparam logic [GAMMA_W-1:0] GAMMA_ONE   = GAMMA_W'(256);

  // Saturating counter increment.
  function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] c);
    return (&c) ? c : c + COUNT_BITS'(1);
  endfunction

endpackage

FILE: hdl/markov_frequency_cache_eviction_unit.sv
// ----------------------------------------------------------------------------
// Markov frequency cache eviction unit
// Small key-value cache that picks victims by access frequency blended with
// learned key-to-key transition counts.
// ----------------------------------------------------------------------------
// Usage:
// - Operations arrive on the slave stream: tuser carries the mode (get, set,
//   remove), tdata the key and the value to store. Each accepted transfer
//   yields exactly one result transfer on the master stream: tuser holds the
//   ok and evicted flags, tdata the read value and the evicted key.
// - One operation at a time. After a transfer is taken, the frequency of the
//   key is fetched, then the slots are walked one per cycle through a
//   single score unit (transition read, two multiplies, add and compare),
//   followed by the pipeline drain, the transition update read and the
//   commit; the next item is accepted only after the result is committed.
// - The result sits in an output register; if the receiver stalls, the
//   commit cycle waits and nothing is lost or repeated.
// - After reset the transition table is cleared, one entry per cycle, all
//   1024 entries; no operation is accepted meanwhile, while configuration
//   writes are always taken.
// ----------------------------------------------------------------------------
module markov_frequency_cache_eviction_unit
  import mfce_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  // Configuration write channel
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic                cfg_index_i,
  input  logic [GAMMA_W-1:0]  cfg_data_i,
  // Operation stream
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [S_DATA_W-1:0] s_axis_tdata,  // key, write_value, zero pad
  input  logic [MODE_W-1:0]   s_axis_tuser,  // mode
  // Result stream
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [M_DATA_W-1:0] m_axis_tdata,  // read_value, evicted_key, zero pad
  output logic [M_USER_W-1:0] m_axis_tuser   // ok, evicted_valid
);

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_FETCH = 3'd2;
  localparam logic [2:0] ST_SCAN  = 3'd3;
  localparam logic [2:0] ST_TRD   = 3'd4;
  localparam logic [2:0] ST_DONE  = 3'd5;

  localparam logic [CNT_W-1:0] SCAN_LAST = CNT_W'(SLOTS + 1);

  logic [2:0]            state_q, state_d;
  logic [CNT_W-1:0]      cnt_q, cnt_d;
  logic [TRANS_AW-1:0]   clr_q;

  logic [CAP_W-1:0]      cap_q;
  logic [GAMMA_W-1:0]    gamma_q;

  logic [COUNT_BITS-1:0] key_freq_q [ALPHABET];
  logic                  slot_valid_q [SLOTS];
  logic [KEY_W-1:0]      slot_key_q [SLOTS];
  logic [VALUE_W-1:0]    slot_value_q [SLOTS];
  logic [KEY_W-1:0]      prev_key_q;
  logic                  prev_valid_q;

  logic [COUNT_BITS-1:0] trans_mem [ALPHABET * ALPHABET];
  logic [COUNT_BITS-1:0] trans_rd_q;
  logic                  trans_re, trans_we;
  logic [TRANS_AW-1:0]   trans_raddr, trans_waddr;
  logic [COUNT_BITS-1:0] trans_wdata;

  // Current operation
  logic [MODE_W-1:0]     mode_q;
  logic [KEY_W-1:0]      key_q;
  logic [VALUE_W-1:0]    wval_q;
  logic [COUNT_BITS-1:0] fc_q;
  logic [GFC_W-1:0]      gfc_q;
  logic [GAMMA_W-1:0]    gc_q;

  // Slot walk results
  logic                  hit_q, free_q;
  logic [SLOT_W-1:0]     hit_idx_q, free_idx_q;
  logic [VALUE_W-1:0]    hit_value_q;
  logic [USED_W-1:0]     used_q;

  // Score pipeline
  logic                  s1_v_q, s2_v_q, best_v_q;
  logic [COUNT_BITS-1:0] s1_fk_q;
  logic [KEY_W-1:0]      s1_key_q, s2_key_q, best_key_q;
  logic [SLOT_W-1:0]     s1_idx_q, s2_idx_q, best_idx_q;
  logic [P1_W-1:0]       s2_p1_q;
  logic [P2_W-1:0]       s2_p2_q;
  logic [SCORE_W-1:0]    best_score_q, score;

  // Output register
  logic                  m_valid_q, m_ok_q, m_ev_q;
  logic [VALUE_W-1:0]    m_value_q;
  logic [KEY_W-1:0]      m_evkey_q;

  logic [SLOT_W-1:0]     scan_idx;
  logic                  scan_live, scan_sv;
  logic [KEY_W-1:0]      scan_sk;
  logic [KEY_W-1:0]      freq_addr;
  logic [COUNT_BITS-1:0] freq_rd;
  logic [GAMMA_W-1:0]    g_eff;
  logic [CAP_W-1:0]      cap_eff;
  logic                  commit, counts, evict, do_set, do_remove;
  logic [SLOT_W-1:0]     tgt_idx;
  logic                  ok_res;

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = (state_q == ST_IDLE);

  assign g_eff   = (gamma_q > GAMMA_ONE) ? GAMMA_ONE : gamma_q;
  assign cap_eff = (cap_q == '0) ? CAP_W'(1) :
                   (cap_q > CAP_W'(SLOTS)) ? CAP_W'(SLOTS) : cap_q;

  assign scan_idx  = cnt_q[SLOT_W-1:0];
  assign scan_live = (state_q == ST_SCAN) && (cnt_q < CNT_W'(SLOTS));
  assign scan_sv   = slot_valid_q[scan_idx];
  assign scan_sk   = slot_key_q[scan_idx];

  assign freq_addr = (state_q == ST_FETCH) ? key_q : scan_sk;
  assign freq_rd   = key_freq_q[freq_addr];

  assign score = SCORE_W'(s2_p1_q) + SCORE_W'(s2_p2_q);

  assign commit    = (state_q == ST_DONE) && (!m_valid_q || m_axis_tready);
  assign counts    = (mode_q == MODE_GET) || (mode_q == MODE_SET);
  assign do_set    = (mode_q == MODE_SET);
  assign do_remove = (mode_q == MODE_REMOVE) && hit_q;
  assign evict     = do_set && !hit_q && (USED_W'(cap_eff) <= used_q);
  assign tgt_idx   = hit_q ? hit_idx_q : (evict ? best_idx_q : free_idx_q);

  always_comb begin
    case (mode_q) inside
      MODE_GET, MODE_REMOVE: ok_res = hit_q;
      MODE_SET:              ok_res = 1'b1;
      default:               ok_res = 1'b0;
    endcase
  end

  // Transition table ports
  always_comb begin
    trans_re    = scan_live || (state_q == ST_TRD);
    trans_raddr = (state_q == ST_TRD) ? {prev_key_q, key_q} : {key_q, scan_sk};
    trans_we    = 1'b0;
    trans_waddr = clr_q;
    trans_wdata = '0;
    if (state_q == ST_CLEAR) begin
      trans_we = 1'b1;
    end else if (commit && counts && prev_valid_q) begin
      trans_we    = 1'b1;
      trans_waddr = {prev_key_q, key_q};
      trans_wdata = sat_inc(trans_rd_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (trans_we) begin
      trans_mem[trans_waddr] <= trans_wdata;
    end
    if (trans_re) begin
      trans_rd_q <= trans_mem[trans_raddr];
    end
  end

  // Sequencer
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    unique case (state_q)
      ST_CLEAR: if (&clr_q) state_d = ST_IDLE;
      ST_IDLE: begin
        if (s_axis_tvalid) state_d = ST_FETCH;
      end
      ST_FETCH: begin
        state_d = ST_SCAN;
        cnt_d   = '0;
      end
      ST_SCAN: begin
        cnt_d = cnt_q + CNT_W'(1);
        if (cnt_q == SCAN_LAST) state_d = ST_TRD;
      end
      ST_TRD:  state_d = ST_DONE;
      ST_DONE: if (commit) state_d = ST_IDLE;
      default: state_d = ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_CLEAR;
      cnt_q        <= '0;
      clr_q        <= '0;
      cap_q        <= CAP_RESET;
      gamma_q      <= GAMMA_RESET;
      prev_key_q   <= '0;
      prev_valid_q <= 1'b0;
      m_valid_q    <= 1'b0;
      s1_v_q       <= 1'b0;
      s2_v_q       <= 1'b0;
      for (int i = 0; i < ALPHABET; i++) key_freq_q[i] <= '0;
      for (int i = 0; i < SLOTS; i++) slot_valid_q[i] <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      s1_v_q  <= scan_live && scan_sv;
      s2_v_q  <= (state_q == ST_SCAN) && s1_v_q;
      if (state_q == ST_CLEAR) clr_q <= clr_q + TRANS_AW'(1);
      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          REG_CAPACITY: cap_q   <= cfg_data_i[CAP_W-1:0];
          REG_GAMMA:    gamma_q <= cfg_data_i;
          default:      ;
        endcase
      end
      if (m_valid_q && m_axis_tready) m_valid_q <= 1'b0;
      if (commit) begin
        m_valid_q <= 1'b1;
        if (counts) begin
          key_freq_q[key_q] <= sat_inc(fc_q);
          prev_key_q        <= key_q;
          prev_valid_q      <= 1'b1;
        end
        if (do_set) slot_valid_q[tgt_idx] <= 1'b1;
        if (do_remove) slot_valid_q[hit_idx_q] <= 1'b0;
      end
    end
  end

  // Operation datapath
  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      mode_q <= s_axis_tuser;
      key_q  <= s_axis_tdata[KEY_W-1:0];
      wval_q <= s_axis_tdata[KEY_W +: VALUE_W];
    end
    if (state_q == ST_FETCH) begin
      // With a zero frequency for the new key the score falls back to g*freq.
      fc_q     <= freq_rd;
      gfc_q    <= (freq_rd == '0) ? GFC_W'(g_eff) : GFC_W'(g_eff) * GFC_W'(freq_rd);
      gc_q     <= (freq_rd == '0) ? '0 : GAMMA_ONE - g_eff;
      hit_q    <= 1'b0;
      free_q   <= 1'b0;
      used_q   <= '0;
      best_v_q <= 1'b0;
    end
    if (scan_live) begin
      if (scan_sv && (scan_sk == key_q) && !hit_q) begin
        hit_q       <= 1'b1;
        hit_idx_q   <= scan_idx;
        hit_value_q <= slot_value_q[scan_idx];
      end
      if (scan_sv) used_q <= used_q + USED_W'(1);
      if (!scan_sv && !free_q) begin
        free_q     <= 1'b1;
        free_idx_q <= scan_idx;
      end
    end
    s1_fk_q  <= freq_rd;
    s1_key_q <= scan_sk;
    s1_idx_q <= scan_idx;
    s2_p1_q  <= P1_W'(gfc_q) * P1_W'(s1_fk_q);
    s2_p2_q  <= P2_W'(gc_q) * P2_W'(trans_rd_q);
    s2_key_q <= s1_key_q;
    s2_idx_q <= s1_idx_q;
    // Strictly lower wins, so ties stay with the lower slot.
    if (s2_v_q && (!best_v_q || (score < best_score_q))) begin
      best_v_q     <= 1'b1;
      best_score_q <= score;
      best_key_q   <= s2_key_q;
      best_idx_q   <= s2_idx_q;
    end
    if (commit) begin
      if (do_set) begin
        slot_key_q[tgt_idx]   <= key_q;
        slot_value_q[tgt_idx] <= wval_q;
      end
      m_ok_q    <= ok_res;
      m_value_q <= ((mode_q == MODE_GET) && hit_q) ? hit_value_q : '0;
      m_ev_q    <= evict;
      m_evkey_q <= evict ? best_key_q : '0;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {{(M_DATA_W - VALUE_W - KEY_W){1'b0}}, m_evkey_q, m_value_q};
  assign m_axis_tuser  = {m_ev_q, m_ok_q};

endmodule

FILE: hdl/mfce_checker.sv
// ----------------------------------------------------------------------------
// Markov frequency cache eviction: port checker
// Watches the stream ports of the top level over time.
// ----------------------------------------------------------------------------
module mfce_checker
  import mfce_pkg::*;
(
  input logic                clk_i,
  input logic                rst_ni,
  input logic                s_axis_tvalid,
  input logic                s_axis_tready,
  input logic                m_axis_tvalid,
  input logic                m_axis_tready,
  input logic [M_DATA_W-1:0] m_axis_tdata,  // read_value, evicted_key, zero pad
  input logic [M_USER_W-1:0] m_axis_tuser   // ok, evicted_valid
);

  // Only one operation is in flight: no second transfer right behind the first.
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input accepted while an operation is in flight");

  // A result needs the full slot walk, so it never appears the cycle after a transfer.
  a_min_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !$rose(m_axis_tvalid))
    else $error("result appeared too early");

  // An eviction only happens on a successful set.
  a_evict_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[1] |-> m_axis_tuser[0])
    else $error("eviction reported without ok");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("stalled result changed");

endmodule

bind markov_frequency_cache_eviction_unit mfce_checker u_mfce_checker (.*);
